### rtl/ltmp_pkg.sv
package ltmp_pkg;

  localparam int unsigned MaxStations = 8;
  localparam int unsigned StIdxW = 3;
  localparam int unsigned CntW = 4;

  // register indexes on the configuration port
  localparam logic [2:0] RegTrackLen  = 3'd0;
  localparam logic [2:0] RegLineSpeed = 3'd1;
  localparam logic [2:0] RegAccel     = 3'd2;
  localparam logic [2:0] RegBrake     = 3'd3;
  localparam logic [2:0] RegDwell     = 3'd4;
  localparam logic [2:0] RegStCount   = 3'd5;

  localparam logic OpTick  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // datapath commands issued by the controller states
  typedef enum logic [3:0] {
    CmdNone   = 4'd0,
    CmdLoad   = 4'd1,
    CmdDwell  = 4'd2,
    CmdCruise = 4'd3,
    CmdDist   = 4'd4,
    CmdProd   = 4'd5,
    CmdSqrt   = 4'd6,
    CmdVel    = 4'd7,
    CmdMove   = 4'd8,
    CmdFinish = 4'd9,
    CmdReport = 4'd10
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic is_write;
    logic dt_zero;
    logic dwell;
    logic no_st;
    logic sqrt_done;
  } stat_t;

endpackage

### rtl/loop_train_motion_profile.sv
// A station write, zero tick or dwell tick goes through the decide and report steps; a
// cruise tick adds cruise, move and finish; a tick that approaches a station adds distance,
// product, the one-bit-a-cycle square root of 2*brake*distance, velocity, move and finish.
// One word is held at a time, the next taken the cycle after the result is taken.
// Reset (rst_ni low, asynchronous) clears motion state and loads the register reset
// values; the station table is undefined until written.
module loop_train_motion_profile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] dt_i,
  input  logic [2:0]  station_index_i,
  input  logic [31:0] station_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] position_o,
  output logic [31:0] velocity_o,
  output logic        dwelling_o,
  output logic [2:0]  target_station_o,
  output logic [31:0] distance_to_stop_o,
  output logic        arrived_o
);

  logic [31:0] len_q, spd_q, acc_q, brk_q, dwl_q;
  logic [3:0]  cnt_q;
  logic [2:0]  reg_idx;
  ltmp_pkg::ctrl_t ctrl;
  ltmp_pkg::stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 32'h0001_0000;
      spd_q <= '0;
      acc_q <= '0;
      brk_q <= '0;
      dwl_q <= '0;
      cnt_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ltmp_pkg::RegTrackLen:  len_q <= pwdata;
        ltmp_pkg::RegLineSpeed: spd_q <= pwdata;
        ltmp_pkg::RegAccel:     acc_q <= pwdata;
        ltmp_pkg::RegBrake:     brk_q <= pwdata;
        ltmp_pkg::RegDwell:     dwl_q <= pwdata;
        ltmp_pkg::RegStCount:   cnt_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ltmp_pkg::RegTrackLen:  prdata = len_q;
      ltmp_pkg::RegLineSpeed: prdata = spd_q;
      ltmp_pkg::RegAccel:     prdata = acc_q;
      ltmp_pkg::RegBrake:     prdata = brk_q;
      ltmp_pkg::RegDwell:     prdata = dwl_q;
      ltmp_pkg::RegStCount:   prdata = {28'd0, cnt_q};
      default:                prdata = '0;
    endcase
  end

  ltmp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  ltmp_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .track_length_i(len_q), .line_speed_i(spd_q), .accel_rate_i(acc_q),
    .brake_rate_i(brk_q), .dwell_time_i(dwl_q), .station_count_i(cnt_q),
    .opcode_i, .dt_i, .station_index_i, .station_position_i,
    .position_o, .velocity_o, .dwelling_o, .target_station_o,
    .distance_to_stop_o, .arrived_o
  );

endmodule

### rtl/ltmp_ctrl.sv
module ltmp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  ltmp_pkg::stat_t stat_i,
  output ltmp_pkg::ctrl_t ctrl_o
);

  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StDecide = 11'b00000000010,
    StDist   = 11'b00000000100,
    StProd   = 11'b00000001000,
    StSqrt   = 11'b00000010000,
    StVel    = 11'b00000100000,
    StMove   = 11'b00001000000,
    StFinish = 11'b00010000000,
    StReport = 11'b00100000000,
    StOut    = 11'b01000000000,
    StCruise = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  ltmp_pkg::cmd_e cmd;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  // sequencing of one word
  always_comb begin
    state_d = state_q;
    cmd     = ltmp_pkg::CmdNone;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StDecide;
          cmd     = ltmp_pkg::CmdLoad;
        end
      end
      StDecide: begin
        if (stat_i.is_write || stat_i.dt_zero) begin
          state_d = StReport;
        end else if (stat_i.dwell) begin
          cmd     = ltmp_pkg::CmdDwell;
          state_d = StReport;
        end else if (stat_i.no_st) begin
          state_d = StCruise;
        end else begin
          state_d = StDist;
        end
      end
      StCruise: begin
        // speed first, then the move and wrap share the station path
        cmd     = ltmp_pkg::CmdCruise;
        state_d = StMove;
      end
      StDist: begin
        cmd     = ltmp_pkg::CmdDist;
        state_d = StProd;
      end
      StProd: begin
        cmd     = ltmp_pkg::CmdProd;
        state_d = StSqrt;
      end
      StSqrt: begin
        // iterate while bits remain; the last cycle only hands over
        if (stat_i.sqrt_done) begin
          state_d = StVel;
        end else begin
          cmd = ltmp_pkg::CmdSqrt;
        end
      end
      StVel: begin
        cmd     = ltmp_pkg::CmdVel;
        state_d = StMove;
      end
      StMove: begin
        cmd     = ltmp_pkg::CmdMove;
        state_d = StFinish;
      end
      StFinish: begin
        cmd     = ltmp_pkg::CmdFinish;
        state_d = StReport;
      end
      StReport: begin
        cmd     = ltmp_pkg::CmdReport;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign ctrl_o.cmd = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // a word is only shown after the report step
  a_out_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == StReport)
    else $error("output without report");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  a_sqrt_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSqrt && stat_i.sqrt_done) |=> state_q == StVel)
    else $error("square root did not end");

endmodule

### rtl/ltmp_dp.sv
module ltmp_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ltmp_pkg::ctrl_t ctrl_i,
  output ltmp_pkg::stat_t stat_o,
  input  logic [31:0]     track_length_i,
  input  logic [31:0]     line_speed_i,
  input  logic [31:0]     accel_rate_i,
  input  logic [31:0]     brake_rate_i,
  input  logic [31:0]     dwell_time_i,
  input  logic [3:0]      station_count_i,
  input  logic            opcode_i,
  input  logic [15:0]     dt_i,
  input  logic [2:0]      station_index_i,
  input  logic [31:0]     station_position_i,
  output logic [31:0]     position_o,
  output logic [31:0]     velocity_o,
  output logic            dwelling_o,
  output logic [2:0]      target_station_o,
  output logic [31:0]     distance_to_stop_o,
  output logic            arrived_o
);

  // state
  logic [31:0] pos_q, vel_q, dwrem_q;
  logic [2:0]  tgt_q;
  logic        dwell_q;
  logic [31:0] table_q [ltmp_pkg::MaxStations];
  // captured word
  logic        op_q;
  logic [15:0] dt_q;
  // working registers
  logic [31:0] dist_q, stp_q, move_q;
  logic [63:0] rad_q, root_q, bit_q;
  logic        cap_sat_q;
  logic        arr_q;

  logic [3:0]  n_eff;
  logic [2:0]  t_eff;
  logic [32:0] len_eff;

  always_comb begin
    n_eff = (station_count_i > 4'(ltmp_pkg::MaxStations)) ?
            4'(ltmp_pkg::MaxStations) : station_count_i;
    t_eff = (n_eff == 4'd0 || {1'b0, tgt_q} >= n_eff) ? 3'd0 : tgt_q;
    len_eff = (track_length_i == 32'd0) ? 33'd1 : {1'b0, track_length_i};
  end

  function automatic logic [31:0] sat33(input logic [32:0] v);
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] scale(input logic [31:0] r, input logic [15:0] d);
    logic [47:0] p;
    p = r * d;
    return p[47:16];
  endfunction

  // forward distance with one conditional add and subtract
  function automatic logic [31:0] fwd(input logic [31:0] st, input logic [31:0] p,
                                      input logic [32:0] l);
    logic [33:0] d;
    d = (st >= p) ? {2'b0, st} - {2'b0, p} : {2'b0, st} + {1'b0, l} - {2'b0, p};
    if (d >= {1'b0, l}) d = d - {1'b0, l};
    return (d[33:32] != 2'b0) ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  assign stat_o.is_write  = (op_q == ltmp_pkg::OpWrite);
  assign stat_o.dt_zero   = (dt_q == 16'd0);
  assign stat_o.dwell     = dwell_q;
  assign stat_o.no_st     = (n_eff == 4'd0);
  assign stat_o.sqrt_done = (bit_q == 64'd0);

  logic [31:0] tgt_spd, acc_v, vnew, dec, vdec, vcap;
  logic [32:0] vsum;
  logic [63:0] trial;
  logic [32:0] pnext;
  logic [63:0] bprod;
  logic        arrive;
  always_comb begin
    vcap    = cap_sat_q ? 32'hFFFF_FFFF : root_q[31:0];
    tgt_spd = (vcap < line_speed_i) ? vcap : line_speed_i;
    vsum    = {1'b0, vel_q} + {1'b0, scale(accel_rate_i, dt_q)};
    acc_v   = sat33(vsum);
    dec     = scale(brake_rate_i, dt_q);
    vdec    = (vel_q > dec) ? vel_q - dec : 32'd0;
    if (vel_q < tgt_spd) vnew = (acc_v < tgt_spd) ? acc_v : tgt_spd;
    else vnew = (vdec > tgt_spd) ? vdec : tgt_spd;
    trial   = root_q + bit_q;
    pnext   = {1'b0, pos_q} + {1'b0, move_q};
    if (pnext >= len_eff) pnext = pnext - len_eff;
    // 32x32 product for the stopping-speed radicand
    bprod   = {32'd0, brake_rate_i} * {32'd0, dist_q};
    // cruise has no station to reach
    arrive  = (n_eff != 4'd0) && (move_q >= dist_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      vel_q   <= '0;
      tgt_q   <= '0;
      dwell_q <= 1'b0;
      dwrem_q <= '0;
    end else begin
      case (ctrl_i.cmd)
        ltmp_pkg::CmdDwell: begin
          if ({16'd0, dt_q} >= dwrem_q) begin
            dwrem_q <= '0;
            dwell_q <= 1'b0;
            if (n_eff != 4'd0)
              tgt_q <= ({1'b0, t_eff} + 4'd1 >= n_eff) ? 3'd0 : t_eff + 3'd1;
          end else begin
            dwrem_q <= dwrem_q - {16'd0, dt_q};
          end
        end
        ltmp_pkg::CmdCruise: begin
          vel_q <= (acc_v < line_speed_i) ? acc_v : line_speed_i;
        end
        ltmp_pkg::CmdDist: tgt_q <= t_eff;
        ltmp_pkg::CmdVel:  vel_q <= vnew;
        ltmp_pkg::CmdFinish: begin
          if (arrive) begin
            pos_q   <= stp_q;
            vel_q   <= '0;
            dwell_q <= 1'b1;
            dwrem_q <= dwell_time_i;
          end else begin
            pos_q <= sat33(pnext);
          end
        end
        default: ;
      endcase
    end
  end

  // working registers and station table
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      ltmp_pkg::CmdLoad: begin
        op_q  <= opcode_i;
        dt_q  <= dt_i;
        arr_q <= 1'b0;
        if (opcode_i == ltmp_pkg::OpWrite) table_q[station_index_i] <= station_position_i;
      end
      ltmp_pkg::CmdDist: begin
        stp_q  <= table_q[t_eff];
        dist_q <= fwd(table_q[t_eff], pos_q, len_eff);
      end
      ltmp_pkg::CmdProd: begin
        rad_q     <= {bprod[62:0], 1'b0};
        cap_sat_q <= bprod[63];
        root_q    <= '0;
        bit_q     <= 64'h4000_0000_0000_0000;
      end
      ltmp_pkg::CmdSqrt: begin
        // one result bit per cycle
        if (rad_q >= trial) begin
          rad_q  <= rad_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ltmp_pkg::CmdMove: move_q <= scale(vel_q, dt_q);
      ltmp_pkg::CmdFinish: arr_q <= arrive;
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == ltmp_pkg::CmdReport) begin
      position_o         <= pos_q;
      velocity_o         <= vel_q;
      dwelling_o         <= dwell_q;
      target_station_o   <= t_eff;
      distance_to_stop_o <= (n_eff == 4'd0) ? 32'd0 : fwd(table_q[t_eff], pos_q, len_eff);
      arrived_o          <= arr_q;
    end
  end

  a_arr_dwell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == ltmp_pkg::CmdFinish && arrive) |=> dwell_q && vel_q == 32'd0)
    else $error("arrival did not stop");

endmodule

### test/tb_loop_train_motion_profile.sv
`timescale 1ns / 1ps

module tb_loop_train_motion_profile;

  localparam int unsigned IdleLimit = 4000;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] vel;
    logic        dwell;
    logic [2:0]  tgt;
    logic [31:0] stop_dist;
    logic        arrived;
  } motion_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        opcode_i = ltmp_pkg::OpTick;
  logic [15:0] dt_i = '0;
  logic [2:0]  station_index_i = '0;
  logic [31:0] station_position_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] position_o;
  logic [31:0] velocity_o;
  logic        dwelling_o;
  logic [2:0]  target_station_o;
  logic [31:0] distance_to_stop_o;
  logic        arrived_o;

  // shadow registers
  logic [31:0] cfg_len = 32'h0001_0000;
  logic [31:0] cfg_line = '0, cfg_accel = '0, cfg_brake = '0, cfg_dwell = '0;
  logic [3:0]  cfg_count = '0;
  // shadow motion state
  logic [31:0] st_pos = '0, st_vel = '0, st_dwell_left = '0;
  logic [2:0]  st_target = '0;
  logic        st_dwelling = 1'b0;
  logic [31:0] st_table [ltmp_pkg::MaxStations];

  motion_t     motion_q [$];
  int unsigned fail_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned gap_max = 11;
  int unsigned stall_max = 11;
  int unsigned hold_cycles = 0;

  loop_train_motion_profile dut (.*);

  always #5 clk_i = ~clk_i;

  // ---------------- predictor ----------------
  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] scaled(logic [31:0] rate, logic [15:0] dt);
    logic [63:0] p;
    p = 64'(rate) * 64'(dt);
    return p[47:16];
  endfunction

  function automatic logic [63:0] eff_len();
    return (cfg_len == 0) ? 64'd1 : 64'(cfg_len);
  endfunction

  function automatic int unsigned eff_count();
    return (cfg_count > ltmp_pkg::MaxStations) ? ltmp_pkg::MaxStations : cfg_count;
  endfunction

  function automatic logic [2:0] eff_target();
    int unsigned n;
    n = eff_count();
    return (n == 0 || st_target >= n) ? 3'd0 : st_target;
  endfunction

  function automatic logic [31:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] ahead_of(logic [31:0] stn);
    logic [63:0] len, d;
    len = eff_len();
    if (stn >= st_pos) d = 64'(stn) - 64'(st_pos);
    else d = 64'(stn) + len - 64'(st_pos);
    if (d >= len) d = d - len;
    return sat32(d);
  endfunction

  function automatic logic [31:0] wrapped(logic [63:0] p);
    if (p >= eff_len()) p = p - eff_len();
    return sat32(p);
  endfunction

  // one tick of motion; returns 1 on arrival
  function automatic logic advance(logic [15:0] dt);
    int unsigned n;
    logic [2:0]  t;
    logic [31:0] span, vcap, goal, v, dec, step;
    logic [63:0] prod;
    n = eff_count();
    if (dt == 0) return 1'b0;
    if (st_dwelling) begin
      if (32'(dt) >= st_dwell_left) begin
        st_dwell_left = '0;
        st_dwelling = 1'b0;
        if (n > 0) st_target = 3'((eff_target() + 1) % n);
      end else begin
        st_dwell_left = st_dwell_left - 32'(dt);
      end
      return 1'b0;
    end
    if (n == 0) begin
      v = sat32(64'(st_vel) + 64'(scaled(cfg_accel, dt)));
      st_vel = (v < cfg_line) ? v : cfg_line;
      st_pos = wrapped(64'(st_pos) + 64'(scaled(st_vel, dt)));
      return 1'b0;
    end
    t = eff_target();
    st_target = t;
    span = ahead_of(st_table[t]);
    prod = 64'(cfg_brake) * 64'(span);
    vcap = prod[63] ? 32'hFFFF_FFFF : root64(prod << 1);
    goal = (vcap < cfg_line) ? vcap : cfg_line;
    if (st_vel < goal) begin
      v = sat32(64'(st_vel) + 64'(scaled(cfg_accel, dt)));
      st_vel = (v < goal) ? v : goal;
    end else begin
      dec = scaled(cfg_brake, dt);
      v = (st_vel > dec) ? st_vel - dec : '0;
      st_vel = (v > goal) ? v : goal;
    end
    step = scaled(st_vel, dt);
    if (step >= span) begin
      st_pos = st_table[t];
      st_vel = '0;
      st_dwelling = 1'b1;
      st_dwell_left = cfg_dwell;
      return 1'b1;
    end
    st_pos = wrapped(64'(st_pos) + 64'(step));
    return 1'b0;
  endfunction

  function automatic motion_t predict_motion(logic op, logic [15:0] dt, logic [2:0] idx,
                                             logic [31:0] sp);
    motion_t m;
    m.arrived = 1'b0;
    if (op == ltmp_pkg::OpWrite) st_table[idx] = sp;
    else m.arrived = advance(dt);
    m.pos = st_pos;
    m.vel = st_vel;
    m.dwell = st_dwelling;
    m.tgt = eff_target();
    m.stop_dist = (eff_count() == 0) ? 32'd0 : ahead_of(st_table[eff_target()]);
    return m;
  endfunction

  // ---------------- drivers ----------------
  // registers change only once the block holds no word
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    in_valid_i <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      ltmp_pkg::RegTrackLen:  cfg_len = val;
      ltmp_pkg::RegLineSpeed: cfg_line = val;
      ltmp_pkg::RegAccel:     cfg_accel = val;
      ltmp_pkg::RegBrake:     cfg_brake = val;
      ltmp_pkg::RegDwell:     cfg_dwell = val;
      ltmp_pkg::RegStCount:   cfg_count = val[3:0];
      default: ;
    endcase
  endtask

  // offer one word; valid stays high on return so a back-to-back word needs no gap
  task automatic send_word(logic op, logic [15:0] dt, logic [2:0] idx, logic [31:0] sp);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    dt_i <= dt;
    station_index_i <= idx;
    station_position_i <= sp;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    motion_q.push_back(predict_motion(op, dt, idx, sp));
  endtask

  task automatic tick(logic [15:0] dt);
    send_word(ltmp_pkg::OpTick, dt, 3'($urandom), $urandom);
  endtask

  task automatic place(logic [2:0] idx, logic [31:0] sp);
    send_word(ltmp_pkg::OpWrite, 16'($urandom), idx, sp);
  endtask

  // sender pause until every expected word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] below_len();
    return (eff_len() <= 1) ? 32'd0 : 32'($urandom_range(0, 32'(eff_len() - 1)));
  endfunction

  // ---------------- receiver stall ----------------
  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      w = $urandom_range(0, stall_max);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && hold_cycles == 0);
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk_i) begin
    motion_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (motion_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected word: pos %h vel %h", position_o, velocity_o);
      end else begin
        e = motion_q.pop_front();
        if (position_o !== e.pos || velocity_o !== e.vel || dwelling_o !== e.dwell ||
            target_station_o !== e.tgt || distance_to_stop_o !== e.stop_dist ||
            arrived_o !== e.arrived) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"mismatch: exp pos %h vel %h dw %b tg %0d dist %h arr %b, ",
                      "got %h %h %b %0d %h %b"},
                     e.pos, e.vel, e.dwell, e.tgt, e.stop_dist, e.arrived, position_o,
                     velocity_o, dwelling_o, target_station_o, distance_to_stop_o, arrived_o);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt == IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_cruise();
    tick(16'd0);
    tick(16'hFFFF);
    reg_write(ltmp_pkg::RegTrackLen, 32'h0010_0000);
    reg_write(ltmp_pkg::RegLineSpeed, 32'h0008_0000);
    reg_write(ltmp_pkg::RegAccel, 32'h0020_0000);
    tick(16'd1);
    tick(16'hFFFF);
    tick(16'hFFFF);
    tick(16'h8000);
    tick(16'd0);
    drain();
  endtask

  // fill every entry before any station count is set
  task automatic test_station_table();
    place(3'd0, 32'd0);
    place(3'd1, 32'h0004_0000);
    place(3'd2, 32'h0008_0000);
    place(3'd3, 32'h000F_FFFF);
    for (int i = 4; i < ltmp_pkg::MaxStations; i++) place(3'(i), below_len());
    drain();
  endtask

  task automatic test_station_stops();
    reg_write(ltmp_pkg::RegBrake, 32'h0010_0000);
    reg_write(ltmp_pkg::RegDwell, 32'h0000_8000);
    reg_write(ltmp_pkg::RegStCount, 32'd3);
    for (int i = 0; i < 40; i++) tick(16'($urandom_range(1, 16'hFFFF)));
    drain();
    // count above the table size, then lowered beneath the target
    reg_write(ltmp_pkg::RegStCount, 32'd15);
    for (int i = 0; i < 30; i++) tick(16'hFFFF);
    drain();
    reg_write(ltmp_pkg::RegStCount, 32'd1);
    tick(16'h4000);
    tick(16'hFFFF);
    drain();
  endtask

  task automatic test_extremes();
    reg_write(ltmp_pkg::RegTrackLen, 32'hFFFF_FFFF);
    reg_write(ltmp_pkg::RegLineSpeed, 32'hFFFF_FFFF);
    reg_write(ltmp_pkg::RegAccel, 32'hFFFF_FFFF);
    reg_write(ltmp_pkg::RegBrake, 32'hFFFF_FFFF);
    reg_write(ltmp_pkg::RegDwell, 32'hFFFF_FFFF);
    reg_write(ltmp_pkg::RegStCount, 32'd8);
    place(3'd0, 32'hFFFF_FFFE);
    for (int i = 0; i < 6; i++) tick(16'hFFFF);
    drain();
    // zero length behaves as one LSB; stations beyond it saturate
    reg_write(ltmp_pkg::RegTrackLen, 32'd0);
    reg_write(ltmp_pkg::RegDwell, 32'd0);
    place(3'd7, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) tick(16'($urandom));
    drain();
    reg_write(ltmp_pkg::RegStCount, 32'd0);
    for (int i = 0; i < 3; i++) tick(16'hFFFF);
    drain();
  endtask

  task automatic random_setup();
    logic [31:0] len;
    len = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(32'h1_0000, 32'h40_0000));
    reg_write(ltmp_pkg::RegTrackLen, len);
    reg_write(ltmp_pkg::RegLineSpeed,
              ($urandom_range(0, 9) == 0) ? $urandom : len >> $urandom_range(0, 3));
    reg_write(ltmp_pkg::RegAccel,
              ($urandom_range(0, 9) == 0) ? $urandom : len << $urandom_range(0, 3));
    reg_write(ltmp_pkg::RegBrake,
              ($urandom_range(0, 9) == 0) ? $urandom : len << $urandom_range(0, 3));
    reg_write(ltmp_pkg::RegDwell,
              ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h1_8000));
    reg_write(ltmp_pkg::RegStCount, $urandom_range(0, 15));
    for (int i = 0; i < ltmp_pkg::MaxStations; i++) place(3'(i), below_len());
  endtask

  task automatic test_random(int unsigned words);
    int unsigned done;
    done = 0;
    while (done < words) begin
      random_setup();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(0, 9) == 0)
          place(3'($urandom), ($urandom_range(0, 7) == 0) ? $urandom : below_len());
        else if ($urandom_range(0, 15) == 0) tick(16'd0);
        else tick(16'($urandom));
      end
      done += 128;
      drain();
    end
    gap_max = 11;
    stall_max = 11;
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    gap_max = 0;
    for (int i = 0; i < 12; i++) tick(16'($urandom));
    gap_max = 11;
    drain();
  endtask

  initial begin
    for (int i = 0; i < ltmp_pkg::MaxStations; i++) st_table[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cruise();
    test_station_table();
    test_station_stops();
    test_extremes();
    test_backpressure();
    test_random(1500);
    drain();
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0 && motion_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### loop_train_motion_profile.f
rtl/ltmp_pkg.sv
rtl/ltmp_ctrl.sv
rtl/ltmp_dp.sv
rtl/loop_train_motion_profile.sv
test/tb_loop_train_motion_profile.sv
